### rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Operation codes, register indexes, register reset values and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

	// Field widths
	localparam int OP_WIDTH     = 2;
	localparam int NOW_WIDTH    = 32;
	localparam int CFG_WIDTH    = 16;
	localparam int REG_IDX_WIDTH = 2;

	// Default timestamp width inside the block
	localparam int TIME_WIDTH_DEF = 32;

	// Operation codes
	localparam logic [OP_WIDTH-1:0] OP_SAMPLE       = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_QUERY_SHORT  = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_QUERY_LONG   = 2'd2;
	localparam logic [OP_WIDTH-1:0] OP_QUERY_DOUBLE = 2'd3;

	// Register indexes
	localparam logic [REG_IDX_WIDTH-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_LONG_PRESS   = 2'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_DOUBLE_PRESS = 2'd2;

	// Register reset values
	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST     = 16'd20;
	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic [CFG_WIDTH-1:0] DOUBLE_PRESS_RST = 16'd300;

	// Configuration as seen by the classifier core
	typedef struct packed {
		logic [CFG_WIDTH-1:0] debounce_time;
		logic [CFG_WIDTH-1:0] long_time;
		logic [CFG_WIDTH-1:0] double_window;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/core/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_if: channel interfaces of the button press classifier
// Sample input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample channel: one button sample plus optional flag query per beat
interface bpc_sample_if;
	import bpc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_WIDTH-1:0]  operation;
	logic                 button_level;
	logic [NOW_WIDTH-1:0] now_ms;

	modport source (output valid, output operation, output button_level, output now_ms,
		input ready);
	modport sink (input valid, input operation, input button_level, input now_ms,
		output ready);
endinterface

// Result channel: one beat per accepted sample
interface bpc_result_if;
	logic valid;
	logic ready;
	logic answer;
	logic held;

	modport source (output valid, output answer, output held, input ready);
	modport sink (input valid, input answer, input held, output ready);
endinterface

// Register write channel
interface bpc_cfg_if;
	import bpc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [REG_IDX_WIDTH-1:0] index;
	logic [CFG_WIDTH-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier: debounced button with short/long/double press
// Samples an active-low button level with a millisecond timestamp, debounces
// it and classifies presses into sticky short, long and double flags that
// can be queried and cleared.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents
//  -------  ---  ---------------------------------------------
//  sample   in   operation, button_level, now_ms
//  result   out  answer, held (one beat per sample beat)
//  cfg      in   index, data (register write, always ready)
//
//  One sample per cycle sustained while result is ready; a sample beat passes
//  through the input register, then the result register. The state update sits
//  in a single pass between the two registers.
//  Reset is asynchronous, active low; registers return to their defaults.
//  A stall on result holds the result register and then the input register;
//  sample.ready drops only when both are full.
//
`default_nettype none

module button_press_classifier #(
	parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bpc_sample_if.sink   sample,
	bpc_result_if.source result,
	bpc_cfg_if.sink      cfg
);
	import bpc_pkg::*;

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic [OP_WIDTH-1:0]   op_s1;
	logic                  level_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  out_valid_q;
	logic                  answer_q;
	logic                  held_q;
	logic                  advance;
	logic                  answer_c;
	logic                  held_c;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DEBOUNCE_RST;
			cfg_q.long_time     <= LONG_PRESS_RST;
			cfg_q.double_window <= DOUBLE_PRESS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEBOUNCE:     cfg_q.debounce_time <= cfg.data;
				REG_LONG_PRESS:   cfg_q.long_time     <= cfg.data;
				REG_DOUBLE_PRESS: cfg_q.double_window <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or drains
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			op_s1    <= sample.operation;
			level_s1 <= sample.button_level;
			now_s1   <= TIME_WIDTH'(sample.now_ms);
		end
	end

	// Classifier state and result logic
	bpc_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.step         (advance),
		.operation    (op_s1),
		.button_level (level_s1),
		.now_ms       (now_s1),
		.answer       (answer_c),
		.held         (held_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			answer_q <= answer_c;
			held_q   <= held_c;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.answer = answer_q;
	assign result.held   = held_q;

endmodule

`default_nettype wire

### rtl/core/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core: debounce and press classification state
// Computes the next state and the result of one sample combinationally and
// commits the state when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_core #(
	parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bpc_pkg::cfg_t                 cfg,
	input  wire logic                          step,
	input  wire logic [bpc_pkg::OP_WIDTH-1:0]  operation,
	input  wire logic                          button_level,
	input  wire logic [TIME_WIDTH-1:0]         now_ms,
	output logic                               answer,
	output logic                               held
);
	import bpc_pkg::*;

	logic                  prev_level_q;
	logic [TIME_WIDTH-1:0] change_time_q;
	logic [TIME_WIDTH-1:0] press_time_q;
	logic [TIME_WIDTH-1:0] release_time_q;
	logic                  held_q;
	logic                  short_q;
	logic                  long_q;
	logic                  double_q;

	logic                  level_chg;
	logic [TIME_WIDTH-1:0] el_change;
	logic [TIME_WIDTH-1:0] el_press;
	logic [TIME_WIDTH-1:0] el_release;
	logic                  stable;
	logic                  press;
	logic                  release_evt;
	logic                  is_long;
	logic                  in_window;
	logic                  held_n;
	logic                  short_n;
	logic                  long_n;
	logic                  double_n;
	logic                  clr_short;
	logic                  clr_long;
	logic                  clr_double;

	// Elapsed times, wrapping at the timestamp width
	assign level_chg  = button_level != prev_level_q;
	assign el_change  = level_chg ? '0 : now_ms - change_time_q;
	assign el_press   = now_ms - press_time_q;
	assign el_release = now_ms - release_time_q;

	// Debounce and press edges
	assign stable      = el_change > TIME_WIDTH'(cfg.debounce_time);
	assign press       = stable && !button_level && !held_q;
	assign release_evt = stable && button_level && held_q;
	assign is_long     = el_press >= TIME_WIDTH'(cfg.long_time);
	assign in_window   = el_release < TIME_WIDTH'(cfg.double_window);

	// Flags after this sample, before any query
	assign held_n   = press | (held_q & ~release_evt);
	assign long_n   = long_q | (release_evt & is_long);
	assign short_n  = short_q | (release_evt & ~is_long);
	assign double_n = double_q | (release_evt & ~is_long & in_window);

	// Query: read one flag and clear it
	always_comb begin
		answer     = 1'b0;
		clr_short  = 1'b0;
		clr_long   = 1'b0;
		clr_double = 1'b0;
		case (operation)
			OP_QUERY_SHORT: begin
				answer    = short_n & ~double_n;
				clr_short = answer;
			end
			OP_QUERY_LONG: begin
				answer   = long_n;
				clr_long = long_n;
			end
			OP_QUERY_DOUBLE: begin
				answer     = double_n;
				clr_double = double_n;
			end
			default: begin
				answer = 1'b0;
			end
		endcase
	end

	assign held = held_n;

	// State commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q   <= 1'b1;
			change_time_q  <= '0;
			press_time_q   <= '0;
			release_time_q <= '0;
			held_q         <= 1'b0;
			short_q        <= 1'b0;
			long_q         <= 1'b0;
			double_q       <= 1'b0;
		end else if (step) begin
			prev_level_q <= button_level;
			if (level_chg) begin
				change_time_q <= now_ms;
			end
			if (press) begin
				press_time_q <= now_ms;
			end
			if (release_evt) begin
				release_time_q <= now_ms;
			end
			held_q   <= held_n;
			short_q  <= short_n & ~clr_short;
			long_q   <= long_n & ~clr_long;
			double_q <= double_n & ~clr_double;
		end
	end

endmodule

`default_nettype wire
